[rtl/mtl_pkg.sv]
// Shared types, token codes and keyword tables for the token lexer.
`default_nettype none
package mtl_pkg;

    // Lexer modes
    typedef enum logic [4:0] {
        M_IDLE, M_NUM_INT, M_NUM_FRAC, M_EXP_START, M_EXP_DIG, M_IDENT,
        M_STR, M_STR_ESC, M_STR_UNI, M_SLASH, M_LINE_COM, M_BLOCK_COM,
        M_BLOCK_STAR, M_EQ, M_BANG, M_LT, M_GT
    } t_mode;

    // One result item
    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [15:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } t_tok;

    localparam logic [5:0] K_NUMBER = 6'd0;
    localparam logic [5:0] K_STRING = 6'd1;
    localparam logic [5:0] K_IDENT  = 6'd2;
    localparam logic [5:0] K_LPAREN = 6'd11;
    localparam logic [5:0] K_RPAREN = 6'd12;
    localparam logic [5:0] K_LBRACE = 6'd13;
    localparam logic [5:0] K_RBRACE = 6'd14;
    localparam logic [5:0] K_LBRACK = 6'd15;
    localparam logic [5:0] K_RBRACK = 6'd16;
    localparam logic [5:0] K_SEMI   = 6'd17;
    localparam logic [5:0] K_COMMA  = 6'd18;
    localparam logic [5:0] K_DOT    = 6'd19;
    localparam logic [5:0] K_COLON  = 6'd20;
    localparam logic [5:0] K_PLUS   = 6'd21;
    localparam logic [5:0] K_MINUS  = 6'd22;
    localparam logic [5:0] K_STAR   = 6'd23;
    localparam logic [5:0] K_DIV    = 6'd24;
    localparam logic [5:0] K_CARET  = 6'd25;
    localparam logic [5:0] K_ASSIGN = 6'd26;
    localparam logic [5:0] K_EQ     = 6'd27;
    localparam logic [5:0] K_NE     = 6'd28;
    localparam logic [5:0] K_LT     = 6'd29;
    localparam logic [5:0] K_LE     = 6'd30;
    localparam logic [5:0] K_GT     = 6'd31;
    localparam logic [5:0] K_GE     = 6'd32;
    localparam logic [5:0] K_ERROR  = 6'd33;
    localparam logic [5:0] K_EOF    = 6'd34;

    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_UNTERM   = 2'd1;
    localparam logic [1:0] E_UNEXPECT = 2'd2;

    localparam int unsigned KW_NUM   = 20;
    localparam int unsigned KW_CHARS = 12;

    // Words that carry a class; text is right-justified (last char in byte 0)
    localparam logic [KW_CHARS-1:0][7:0] KW_TEXT [KW_NUM] = '{
        "element", "sphere", "shell", "point",
        "material", "animation", "keyframe", "transition",
        "behavior", "physics", "force", "collision",
        "bot", "agent", "parallel", "distributed",
        "solid", "liquid", "gas", "plasma"
    };
    localparam int unsigned KW_LEN [KW_NUM] = '{
        7, 6, 5, 5, 8, 9, 8, 10, 8, 7, 5, 9, 3, 5, 8, 11, 5, 6, 3, 6
    };
    localparam logic [5:0] KW_KIND [KW_NUM] = '{
        6'd3, 6'd3, 6'd3, 6'd3, 6'd4, 6'd4, 6'd4, 6'd4,
        6'd5, 6'd5, 6'd5, 6'd5, 6'd6, 6'd6, 6'd6, 6'd6,
        6'd7, 6'd8, 6'd9, 6'd10
    };
    // Bit n set: the class applies under language n (matter words always)
    localparam logic [3:0] KW_LANG [KW_NUM] = '{
        4'b0001, 4'b0001, 4'b0001, 4'b0001,
        4'b0011, 4'b0010, 4'b0010, 4'b0010,
        4'b0101, 4'b0100, 4'b0100, 4'b0100,
        4'b1000, 4'b1000, 4'b1000, 4'b1000,
        4'b1111, 4'b1111, 4'b1111, 4'b1111
    };

    localparam int unsigned OUTQ_DEPTH = 4;

endpackage
`default_nettype wire

[rtl/markup_token_lexer_core.sv]
// Top level of the streaming token lexer.
//
//  channel | direction | signals
//  input   | in        | i_in_valid / o_in_ready, i_op, i_char_code
//  result  | out       | o_out_valid / i_out_ready, o_token_kind .. o_last
//  config  | in        | i_cfg_we, i_cfg_wdata (language select)
//
// One byte is lexed in the cycle it is transferred; its tokens (zero to two)
// enter a four-entry queue and appear from the next cycle on.
// Input is taken whenever the queue has room for two tokens, so one byte per
// cycle is sustained while no byte gives two tokens and the result side takes one token per cycle.
// Synchronous active-low reset returns to line 1, column 1, language 0.
`default_nettype none
module markup_token_lexer_core #(
    parameter int unsigned MAX_KEYWORD_LEN = 15,
    parameter int unsigned POSITION_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [0:0]  i_op,
    input  wire logic [7:0]  i_char_code,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [5:0]       o_token_kind,
    output logic [1:0]       o_error_kind,
    output logic [15:0]      o_token_length,
    output logic [15:0]      o_start_line,
    output logic [15:0]      o_start_column,
    output logic             o_last
);
    import mtl_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    logic [1:0]               r_lang;
    t_mode                    r_mode, n_mode;
    logic                     r_quote, n_quote;
    logic [2:0]               r_esc, n_esc;
    logic [7:0]               r_buf [MAX_KEYWORD_LEN];
    logic [7:0]               n_buf [MAX_KEYWORD_LEN];
    logic [15:0]              r_run, n_run;
    logic [POSITION_BITS-1:0] r_line, n_line, r_col, n_col;
    logic [POSITION_BITS-1:0] r_tline, n_tline, r_tcol, n_tcol;

    logic        accept;
    logic [7:0]  c, c_low;
    logic        is_dig, is_alp, is_ws;
    logic [7:0]  cmp [KW_CHARS];
    logic [5:0]  word_kind;
    logic        fl_emit;
    logic [5:0]  fl_kind;
    logic [1:0]  fl_err;
    logic        st_emit;
    logic [5:0]  st_kind;
    logic [1:0]  st_err;
    t_mode       st_mode;
    logic        redo;
    logic [1:0]  cnt;
    t_tok        tok0, tok1, tmp;
    logic [15:0] run_inc;
    logic        q_room;
    t_tok        q_tok;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = q_room;
    assign c          = i_char_code;
    assign is_dig     = (c >= "0") && (c <= "9");
    assign is_alp     = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    assign is_ws      = (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    assign c_low      = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    assign run_inc    = (r_run != 16'hFFFF) ? r_run + 16'd1 : r_run;

    // Word buffer view cut or padded to the width of the class word text
    for (genvar g = 0; g < KW_CHARS; g++) begin : g_cmp
        if (g < MAX_KEYWORD_LEN) begin : g_in
            assign cmp[g] = r_buf[g];
        end else begin : g_out
            assign cmp[g] = 8'd0;
        end
    end

    // Classify the buffered word against all class words in parallel
    always_comb begin
        logic hit;
        word_kind = K_IDENT;
        for (int w = 0; w < KW_NUM; w++) begin
            hit = (r_run == 16'(KW_LEN[w]));
            for (int i = 0; i < KW_CHARS; i++) begin
                if (i < KW_LEN[w]) begin
                    hit = hit && (cmp[i] == KW_TEXT[w][KW_LEN[w] - 1 - i]);
                end
            end
            if (hit && KW_LANG[w][r_lang]) begin
                word_kind = KW_KIND[w];
            end
        end
    end

    // Pending token that a flush would give
    always_comb begin
        fl_emit = 1'b1;
        fl_kind = K_NUMBER;
        fl_err  = E_NONE;
        unique case (r_mode)
            M_NUM_INT, M_NUM_FRAC, M_EXP_START, M_EXP_DIG: fl_kind = K_NUMBER;
            M_IDENT:  fl_kind = word_kind;
            M_STR, M_STR_ESC, M_STR_UNI: begin
                fl_kind = K_ERROR;
                fl_err  = E_UNTERM;
            end
            M_SLASH:  fl_kind = K_DIV;
            M_EQ:     fl_kind = K_ASSIGN;
            M_BANG: begin
                fl_kind = K_ERROR;
                fl_err  = E_UNEXPECT;
            end
            M_LT:     fl_kind = K_LT;
            M_GT:     fl_kind = K_GT;
            default:  fl_emit = 1'b0;
        endcase
    end

    // Decode of a byte that opens a token
    always_comb begin
        st_emit = 1'b1;
        st_kind = K_ERROR;
        st_err  = E_NONE;
        st_mode = M_IDLE;
        if (is_dig) begin
            st_emit = 1'b0;
            st_mode = M_NUM_INT;
        end else if (is_alp) begin
            st_emit = 1'b0;
            st_mode = M_IDENT;
        end else begin
            case (c)
                "\"", "'": begin st_emit = 1'b0; st_mode = M_STR;   end
                "/":       begin st_emit = 1'b0; st_mode = M_SLASH; end
                "=":       begin st_emit = 1'b0; st_mode = M_EQ;    end
                "!":       begin st_emit = 1'b0; st_mode = M_BANG;  end
                "<":       begin st_emit = 1'b0; st_mode = M_LT;    end
                ">":       begin st_emit = 1'b0; st_mode = M_GT;    end
                "(": st_kind = K_LPAREN;
                ")": st_kind = K_RPAREN;
                "{": st_kind = K_LBRACE;
                "}": st_kind = K_RBRACE;
                "[": st_kind = K_LBRACK;
                "]": st_kind = K_RBRACK;
                ";": st_kind = K_SEMI;
                ",": st_kind = K_COMMA;
                ".": st_kind = K_DOT;
                ":": st_kind = K_COLON;
                "+": st_kind = K_PLUS;
                "-": st_kind = K_MINUS;
                "*": st_kind = K_STAR;
                "^": st_kind = K_CARET;
                default: st_err = E_UNEXPECT;
            endcase
        end
    end

    // Step the lexer for one transferred item
    always_comb begin
        n_mode  = r_mode;
        n_quote = r_quote;
        n_esc   = r_esc;
        n_buf   = r_buf;
        n_run   = r_run;
        n_line  = r_line;
        n_col   = r_col;
        n_tline = r_tline;
        n_tcol  = r_tcol;
        redo    = 1'b0;
        cnt     = 2'd0;
        tok0    = '0;
        tok1    = '0;
        tmp     = '0;

        if (i_op[0]) begin
            // flush, give eof, then return to idle mode at line 1, column 1
            if (fl_emit) begin
                tok0 = '{fl_kind, fl_err, r_run, 16'(r_tline), 16'(r_tcol), 1'b0};
                cnt  = 2'd1;
            end
            tmp = '{K_EOF, E_NONE, 16'd0, 16'(r_line), 16'(r_col), 1'b0};
            if (cnt == 2'd0) tok0 = tmp; else tok1 = tmp;
            cnt     = cnt + 2'd1;
            n_mode  = M_IDLE;
            n_quote = 1'b0;
            n_esc   = 3'd0;
            n_run   = 16'd0;
            n_line  = POS_ONE;
            n_col   = POS_ONE;
            n_tline = POS_ONE;
            n_tcol  = POS_ONE;
        end else begin
            unique case (r_mode)
                M_IDLE: redo = 1'b1;
                M_NUM_INT, M_NUM_FRAC: begin
                    if (is_dig) begin
                        n_run = run_inc;
                    end else if (c == "." && r_mode == M_NUM_INT) begin
                        n_run  = run_inc;
                        n_mode = M_NUM_FRAC;
                    end else if (c == "e" || c == "E") begin
                        n_run  = run_inc;
                        n_mode = M_EXP_START;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_EXP_START: begin
                    if (is_dig || c == "+" || c == "-") begin
                        n_run  = run_inc;
                        n_mode = M_EXP_DIG;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_EXP_DIG: begin
                    if (is_dig) n_run = run_inc;
                    else redo = 1'b1;
                end
                M_IDENT: begin
                    if (is_alp || is_dig) begin
                        for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
                            if (r_run == 16'(i)) n_buf[i] = c_low;
                        end
                        n_run = run_inc;
                    end else begin
                        redo = 1'b1;
                    end
                end
                M_STR: begin
                    n_run = run_inc;
                    if (c == "\\") begin
                        n_mode = M_STR_ESC;
                    end else if (c == (r_quote ? 8'h27 : 8'h22)) begin
                        tok0   = '{K_STRING, E_NONE, run_inc, 16'(r_tline), 16'(r_tcol), 1'b0};
                        cnt    = 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_STR_ESC: begin
                    n_run = run_inc;
                    if (c == "u") begin
                        n_esc  = 3'd4;
                        n_mode = M_STR_UNI;
                    end else begin
                        n_mode = M_STR;
                    end
                end
                M_STR_UNI: begin
                    n_run = run_inc;
                    n_esc = r_esc - 3'd1;
                    if (r_esc == 3'd1) n_mode = M_STR;
                end
                M_SLASH: begin
                    if (c == "/") n_mode = M_LINE_COM;
                    else if (c == "*") n_mode = M_BLOCK_COM;
                    else redo = 1'b1;
                end
                M_LINE_COM: begin
                    if (c == 8'h0A) n_mode = M_IDLE;
                end
                M_BLOCK_COM: begin
                    if (c == "*") n_mode = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    if (c == "/") n_mode = M_IDLE;
                    else if (c != "*") n_mode = M_BLOCK_COM;
                end
                M_EQ, M_BANG, M_LT, M_GT: begin
                    if (c == "=") begin
                        tmp.kind = (r_mode == M_EQ)   ? K_EQ :
                                   (r_mode == M_BANG) ? K_NE :
                                   (r_mode == M_LT)   ? K_LE : K_GE;
                        tok0   = '{tmp.kind, E_NONE, run_inc, 16'(r_tline), 16'(r_tcol), 1'b0};
                        cnt    = 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        redo = 1'b1;
                    end
                end
                default: redo = 1'b1;
            endcase

            // flush the pending token, then open a new one with this byte unless it is whitespace
            if (redo) begin
                if (fl_emit) begin
                    tok0 = '{fl_kind, fl_err, r_run, 16'(r_tline), 16'(r_tcol), 1'b0};
                    cnt  = 2'd1;
                end
                n_mode = M_IDLE;
                if (!is_ws) begin
                    n_tline = r_line;
                    n_tcol  = r_col;
                    n_run   = 16'd1;
                    n_mode  = st_mode;
                    if (is_alp) n_buf[0] = c_low;
                    if (c == "\"" || c == "'") n_quote = (c == "'");
                    if (st_emit) begin
                        tmp = '{st_kind, st_err, 16'd1, 16'(r_line), 16'(r_col), 1'b0};
                        if (cnt == 2'd0) tok0 = tmp; else tok1 = tmp;
                        cnt = cnt + 2'd1;
                    end
                end
            end

            // advance the source position
            if (c == 8'h0A) begin
                if (r_line != '1) n_line = r_line + POS_ONE;
                n_col = POS_ONE;
            end else if (r_col != '1) begin
                n_col = r_col + POS_ONE;
            end
        end

        if (cnt == 2'd1) tok0.last = 1'b1;
        if (cnt == 2'd2) tok1.last = 1'b1;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lang  <= 2'd0;
            r_mode  <= M_IDLE;
            r_quote <= 1'b0;
            r_esc   <= 3'd0;
            r_run   <= 16'd0;
            r_line  <= POS_ONE;
            r_col   <= POS_ONE;
            r_tline <= POS_ONE;
            r_tcol  <= POS_ONE;
        end else begin
            if (i_cfg_we) r_lang <= i_cfg_wdata;
            if (accept) begin
                r_mode  <= n_mode;
                r_quote <= n_quote;
                r_esc   <= n_esc;
                r_run   <= n_run;
                r_line  <= n_line;
                r_col   <= n_col;
                r_tline <= n_tline;
                r_tcol  <= n_tcol;
            end
        end
    end

    // Word buffer
    always_ff @(posedge i_clk) begin
        if (accept) r_buf <= n_buf;
    end

    mtl_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (accept ? cnt : 2'd0),
        .i_tok0     (tok0),
        .i_tok1     (tok1),
        .o_room     (q_room),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_tok      (q_tok)
    );

    assign o_token_kind   = q_tok.kind;
    assign o_error_kind   = q_tok.err;
    assign o_token_length = q_tok.len;
    assign o_start_line   = q_tok.line;
    assign o_start_column = q_tok.col;
    assign o_last         = q_tok.last;

endmodule
`default_nettype wire

[rtl/mtl_outq.sv]
// Four-entry result queue taking up to two tokens per cycle.
`default_nettype none
module mtl_outq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [1:0]    i_push_cnt,
    input  wire mtl_pkg::t_tok i_tok0,
    input  wire mtl_pkg::t_tok i_tok1,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mtl_pkg::t_tok      o_tok
);
    import mtl_pkg::*;

    t_tok       r_mem [OUTQ_DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [1:0] n_wp, n_rp;
    logic [2:0] n_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_room  = (r_cnt <= 3'd2);
    assign o_tok   = r_mem[r_rp];
    assign pop     = o_valid && i_ready;

    // Advance pointers and fill level
    always_comb begin
        n_wp  = r_wp + i_push_cnt;
        n_rp  = r_rp + {1'b0, pop};
        n_cnt = r_cnt + {1'b0, i_push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store new tokens
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_tok0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_tok1;
        end
    end

endmodule
`default_nettype wire
